// ===== hw/rtl/cvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cvsm_pkg
// Shared types and constants of the cell voltage scan monitor.
// ----------------------------------------------------------------------------
package cvsm_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SOC_W  = 7;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Codes above this mark a cell that could not be read
  localparam logic [CODE_W-1:0] NOT_READ_CODE    = 16'd65000;
  // Pack high margin below the full level (5 V)
  localparam logic [SUM_W-1:0]  PACK_HIGH_MARGIN = 24'd50000;
  localparam logic [SOC_W-1:0]  SOC_MAX          = 7'd100;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_OVER_VOLTAGE  = 3'd0;
  localparam logic [2:0] REG_ALMOST_FULL   = 3'd1;
  localparam logic [2:0] REG_UNDER_VOLTAGE = 3'd2;
  localparam logic [2:0] REG_ABSOLUTE_MAX  = 3'd3;
  localparam logic [2:0] REG_ABSOLUTE_MIN  = 3'd4;
  localparam logic [2:0] REG_PACK_FULL     = 3'd5;
  localparam logic [2:0] REG_PACK_LOW      = 3'd6;
  localparam logic [2:0] REG_SKIP_CELL     = 3'd7;

  // Register reset values
  localparam logic [CODE_W-1:0] RST_OVER_VOLTAGE  = 16'd41600;
  localparam logic [CODE_W-1:0] RST_ALMOST_FULL   = 16'd40000;
  localparam logic [CODE_W-1:0] RST_UNDER_VOLTAGE = 16'd26000;
  localparam logic [CODE_W-1:0] RST_ABSOLUTE_MAX  = 16'd42000;
  localparam logic [CODE_W-1:0] RST_ABSOLUTE_MIN  = 16'd25000;
  localparam logic [SUM_W-1:0]  RST_PACK_FULL     = 24'd2997000;
  localparam logic [SUM_W-1:0]  RST_PACK_LOW      = 24'd1920000;
  localparam logic [IDX_W-1:0]  RST_SKIP_CELL     = 4'd5;

  typedef struct packed {
    logic [CODE_W-1:0] over_voltage_code;
    logic [CODE_W-1:0] almost_full_code;
    logic [CODE_W-1:0] under_voltage_code;
    logic [CODE_W-1:0] absolute_max_code;
    logic [CODE_W-1:0] absolute_min_code;
    logic [SUM_W-1:0]  pack_full_code;
    logic [SUM_W-1:0]  pack_low_code;
    logic [IDX_W-1:0]  skip_cell_index;
  } cfg_t;

  typedef struct packed {
    logic fault;
    logic too_low;
    logic too_high;
    logic low_warning;
    logic full;
    logic almost_full;
  } flags_t;

  // Status of the serial accumulator toward the sequencer
  typedef struct packed {
    logic              done;
    logic              missing;
    flags_t            flags;
    logic [SUM_W-1:0]  sum;
  } acc_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PACK,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

// ===== hw/rtl/cvsm_regs.sv =====
// ----------------------------------------------------------------------------
// cvsm_regs
// Configuration register file on an APB-style port.
// ----------------------------------------------------------------------------
module cvsm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvsm_pkg::DATA_W-1:0]   pwdata,
  output logic [cvsm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cvsm_pkg::cfg_t                cfg
);
  import cvsm_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_voltage_code  <= RST_OVER_VOLTAGE;
      cfg.almost_full_code   <= RST_ALMOST_FULL;
      cfg.under_voltage_code <= RST_UNDER_VOLTAGE;
      cfg.absolute_max_code  <= RST_ABSOLUTE_MAX;
      cfg.absolute_min_code  <= RST_ABSOLUTE_MIN;
      cfg.pack_full_code     <= RST_PACK_FULL;
      cfg.pack_low_code      <= RST_PACK_LOW;
      cfg.skip_cell_index    <= RST_SKIP_CELL;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OVER_VOLTAGE:  cfg.over_voltage_code  <= pwdata[CODE_W-1:0];
        REG_ALMOST_FULL:   cfg.almost_full_code   <= pwdata[CODE_W-1:0];
        REG_UNDER_VOLTAGE: cfg.under_voltage_code <= pwdata[CODE_W-1:0];
        REG_ABSOLUTE_MAX:  cfg.absolute_max_code  <= pwdata[CODE_W-1:0];
        REG_ABSOLUTE_MIN:  cfg.absolute_min_code  <= pwdata[CODE_W-1:0];
        REG_PACK_FULL:     cfg.pack_full_code     <= pwdata[SUM_W-1:0];
        REG_PACK_LOW:      cfg.pack_low_code      <= pwdata[SUM_W-1:0];
        REG_SKIP_CELL:     cfg.skip_cell_index    <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_OVER_VOLTAGE:  prdata = DATA_W'(cfg.over_voltage_code);
      REG_ALMOST_FULL:   prdata = DATA_W'(cfg.almost_full_code);
      REG_UNDER_VOLTAGE: prdata = DATA_W'(cfg.under_voltage_code);
      REG_ABSOLUTE_MAX:  prdata = DATA_W'(cfg.absolute_max_code);
      REG_ABSOLUTE_MIN:  prdata = DATA_W'(cfg.absolute_min_code);
      REG_PACK_FULL:     prdata = DATA_W'(cfg.pack_full_code);
      REG_PACK_LOW:      prdata = DATA_W'(cfg.pack_low_code);
      REG_SKIP_CELL:     prdata = DATA_W'(cfg.skip_cell_index);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cvsm_accum.sv =====
// ----------------------------------------------------------------------------
// cvsm_accum
// Bit-serial cell unit: adds one cell code, unless it marks a cell not read, into
// the running pack sum and classifies it against the limits, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cvsm_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  cvsm_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic                          clear,
  input  logic [cvsm_pkg::CODE_W-1:0]   cell_code,
  input  logic [cvsm_pkg::IDX_W-1:0]    cell_index,
  output cvsm_pkg::acc_status_t         status
);
  import cvsm_pkg::*;

  localparam logic [4:0] LAST_BIT = 5'(SUM_W - 1);

  logic [CODE_W-1:0] code_sh;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  part_sum;
  logic [SUM_W-1:0]  part_sum_next;
  logic [4:0]        cnt;
  logic              busy;
  logic              carry;
  logic              carry_next;
  logic              skip;
  logic              missing;
  flags_t            flags;
  flags_t            cell_flags;

  // Serial magnitude compares: the last differing bit decides
  logic ov_ge, af_ge, uv_ge, max_gt, min_ge, nr_gt;
  logic ov_ge_next, af_ge_next, uv_ge_next, max_gt_next, min_ge_next, nr_gt_next;

  logic a_bit, s_bit, last_step, in_code;
  logic [3:0] bit_sel;

  function automatic logic cmp_step(input logic f, input logic a, input logic b);
    cmp_step = (a ^ b) ? a : f;
  endfunction

  assign a_bit     = code_sh[0];
  assign bit_sel   = cnt[3:0];
  assign in_code   = !cnt[4];
  assign last_step = busy && (cnt == LAST_BIT);

  // Full adder and compare step on the current bit
  always_comb begin
    s_bit         = sum[0] ^ a_bit ^ carry;
    carry_next    = (sum[0] & a_bit) | (carry & (sum[0] ^ a_bit));
    part_sum_next = {s_bit, part_sum[SUM_W-1:1]};
    ov_ge_next    = cmp_step(ov_ge,  a_bit, in_code && cfg.over_voltage_code[bit_sel]);
    af_ge_next    = cmp_step(af_ge,  a_bit, in_code && cfg.almost_full_code[bit_sel]);
    uv_ge_next    = cmp_step(uv_ge,  a_bit, in_code && cfg.under_voltage_code[bit_sel]);
    max_gt_next   = cmp_step(max_gt, a_bit, in_code && cfg.absolute_max_code[bit_sel]);
    min_ge_next   = cmp_step(min_ge, a_bit, in_code && cfg.absolute_min_code[bit_sel]);
    nr_gt_next    = cmp_step(nr_gt,  a_bit, in_code && NOT_READ_CODE[bit_sel]);
  end

  // Classify the cell from the finished compares
  always_comb begin
    cell_flags             = '0;
    cell_flags.too_high    = !skip && max_gt;
    cell_flags.too_low     = !skip && !max_gt && !min_ge;
    cell_flags.fault       = !skip && (max_gt || !min_ge);
    cell_flags.full        = ov_ge;
    cell_flags.almost_full = ov_ge || af_ge;
    cell_flags.low_warning = !ov_ge && !af_ge && !uv_ge && !skip;
  end

  // Scan state and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cnt     <= '0;
      sum     <= '0;
      flags   <= '0;
      missing <= 1'b0;
    end else if (clear) begin
      sum     <= '0;
      flags   <= '0;
      missing <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (last_step) begin
        busy <= 1'b0;
        if (nr_gt) begin
          missing <= 1'b1;
          sum     <= {sum[0], sum[SUM_W-1:1]};
        end else begin
          sum   <= carry_next ? '1 : part_sum_next;
          flags <= flags | cell_flags;
        end
      end else begin
        // rotate so the sum is back in place after a full pass
        sum <= {sum[0], sum[SUM_W-1:1]};
      end
    end
  end

  // Serial datapath
  always_ff @(posedge clk) begin
    if (start) begin
      code_sh <= cell_code;
      skip    <= (cell_index == cfg.skip_cell_index);
      carry   <= 1'b0;
      ov_ge   <= 1'b1;
      af_ge   <= 1'b1;
      uv_ge   <= 1'b1;
      max_gt  <= 1'b0;
      min_ge  <= 1'b1;
      nr_gt   <= 1'b0;
    end else if (busy) begin
      code_sh  <= {1'b0, code_sh[CODE_W-1:1]};
      part_sum <= part_sum_next;
      carry    <= carry_next;
      ov_ge    <= ov_ge_next;
      af_ge    <= af_ge_next;
      uv_ge    <= uv_ge_next;
      max_gt   <= max_gt_next;
      min_ge   <= min_ge_next;
      nr_gt    <= nr_gt_next;
    end
  end

  assign status.done    = last_step;
  assign status.missing = missing;
  assign status.flags   = flags;
  assign status.sum     = sum;

endmodule

// ===== hw/rtl/cvsm_soc.sv =====
// ----------------------------------------------------------------------------
// cvsm_soc
// State of charge unit: floor(sum * 100 / full), saturated at 100, by a
// restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvsm_soc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cvsm_pkg::SUM_W-1:0]   sum,
  input  logic [cvsm_pkg::SUM_W-1:0]   full,
  output logic                         done,
  output logic [cvsm_pkg::SOC_W-1:0]   soc
);
  import cvsm_pkg::*;

  localparam int unsigned PROD_W = SUM_W + SOC_W;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rem;
  logic [SOC_W-1:0]  num_lo;
  logic [SOC_W-1:0]  quo;
  logic [2:0]        cnt;
  logic              busy;
  logic              sat;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              fits;

  // Scale the sum once per scan
  assign prod = PROD_W'(sum) * PROD_W'(SOC_MAX);

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem, num_lo[SOC_W-1]};
    diff  = trial - {1'b0, full};
    fits  = (trial >= {1'b0, full});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'(SOC_W);
    end else if (busy) begin
      cnt <= cnt - 3'd1;
      if (cnt == 3'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient of at least 100 whenever sum reaches full
      sat    <= (sum >= full);
      rem    <= prod[PROD_W-1:SOC_W];
      num_lo <= prod[SOC_W-1:0];
      quo    <= '0;
    end else if (busy) begin
      rem    <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      num_lo <= {num_lo[SOC_W-2:0], 1'b0};
      quo    <= {quo[SOC_W-2:0], fits};
    end
  end

  assign done = busy && (cnt == 3'd1);
  assign soc  = sat ? SOC_MAX : quo;

endmodule

// ===== hw/rtl/cell_voltage_scan_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_scan_monitor_unit
// Battery cell voltage monitor over one pack scan, bit-serial datapath.
// ----------------------------------------------------------------------------
// Each request carries one cell code. After the request is accepted the bit-serial
// adder folds the code into the 24-bit pack sum while the limit compares run on
// the same bits; no new cell is taken before that is done. The request marked
// last_cell then goes on through the pack limit check, the seven quotient bits
// of the state-of-charge divider and the result load, and produces one
// result; other requests produce none. The result sits in an output register,
// so the block takes new cells while it waits, and a following scan end
// waits only if that register is still full.
// ----------------------------------------------------------------------------
module cell_voltage_scan_monitor_unit (
  input  logic                          clk,
  input  logic                          rst,
  // cell channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cvsm_pkg::CODE_W-1:0]   cell_code,
  input  logic [cvsm_pkg::IDX_W-1:0]    cell_index,
  input  logic                          last_cell,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cvsm_pkg::SUM_W-1:0]    pack_voltage,
  output logic                          almost_full_flag,
  output logic                          full_flag,
  output logic                          low_warning_flag,
  output logic                          too_high_flag,
  output logic                          too_low_flag,
  output logic                          fault_flag,
  output logic                          pack_high_flag,
  output logic                          pack_low_flag,
  output logic                          any_not_read,
  output logic [cvsm_pkg::SOC_W-1:0]    state_of_charge,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvsm_pkg::DATA_W-1:0]   pwdata,
  output logic [cvsm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cvsm_pkg::*;

  cfg_t          cfg;
  acc_status_t   acc;
  state_t        state;
  state_t        state_next;

  logic              accept;
  logic              last_r;
  logic              soc_start;
  logic              soc_done;
  logic [SOC_W-1:0]  soc_q;
  logic              load;
  logic              pack_high;
  logic              pack_low;
  logic              pack_high_r;
  logic              pack_low_r;
  logic [SOC_W-1:0]  last_soc;
  logic [SOC_W-1:0]  soc_out;

  cvsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cvsm_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (accept),
    .clear      (load),
    .cell_code  (cell_code),
    .cell_index (cell_index),
    .status     (acc)
  );

  cvsm_soc u_soc (
    .clk   (clk),
    .rst   (rst),
    .start (soc_start),
    .sum   (acc.sum),
    .full  (cfg.pack_full_code),
    .done  (soc_done),
    .soc   (soc_q)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (acc.done) state_next = last_r ? ST_PACK : ST_IDLE;
      ST_PACK: state_next = ST_DIV;
      ST_DIV:  if (soc_done) state_next = ST_HOLD;
      ST_HOLD: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    soc_start = 1'b0;
    load      = 1'b0;
    unique case (state)
      ST_IDLE: in_stall  = 1'b0;
      ST_SCAN: ;
      ST_PACK: soc_start = 1'b1;
      ST_DIV:  ;
      ST_HOLD: load      = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the scan-end mark of the request in work
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last_cell;
    end
  end

  // Pack limits, high tested first
  always_comb begin
    pack_high = !acc.missing &&
                (({1'b0, acc.sum} + {1'b0, PACK_HIGH_MARGIN}) > {1'b0, cfg.pack_full_code});
    pack_low  = !acc.missing && !pack_high && (acc.sum < cfg.pack_low_code);
  end

  always_ff @(posedge clk) begin
    if (state == ST_PACK) begin
      pack_high_r <= pack_high;
      pack_low_r  <= pack_low;
    end
  end

  // Keep the previous SoC while a pack flag is set
  assign soc_out = (pack_high_r || pack_low_r) ? last_soc : soc_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_soc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        last_soc  <= soc_out;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      pack_voltage     <= acc.sum;
      almost_full_flag <= acc.flags.almost_full;
      full_flag        <= acc.flags.full;
      low_warning_flag <= acc.flags.low_warning;
      too_high_flag    <= acc.flags.too_high;
      too_low_flag     <= acc.flags.too_low;
      fault_flag       <= acc.flags.fault;
      pack_high_flag   <= pack_high_r;
      pack_low_flag    <= pack_low_r;
      any_not_read     <= acc.missing;
      state_of_charge  <= soc_out;
    end
  end

endmodule

// ===== hw/rtl/cvsm_checker.sv =====
// ----------------------------------------------------------------------------
// cvsm_checker
// Port-level checks of the cell voltage scan monitor, bound to the top level.
// ----------------------------------------------------------------------------
module cvsm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          full_flag,
  input logic                          almost_full_flag,
  input logic                          too_high_flag,
  input logic                          too_low_flag,
  input logic                          fault_flag,
  input logic                          pack_high_flag,
  input logic                          pack_low_flag,
  input logic                          any_not_read,
  input logic [cvsm_pkg::SOC_W-1:0]    state_of_charge
);
  import cvsm_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(state_of_charge))
    else $error("stalled result dropped or changed");

  // Saturate the state of charge
  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state_of_charge <= SOC_MAX)
    else $error("state of charge above full");

  // Raise at most one pack flag
  a_pack_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pack_high_flag && pack_low_flag))
    else $error("pack high and pack low together");

  // Raise pack flags only on a fully read scan
  a_pack_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pack_high_flag || pack_low_flag) |-> !any_not_read)
    else $error("pack flag on an incomplete scan");

  // Keep cell flags consistent with one another
  a_flag_imply: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!full_flag || almost_full_flag) &&
                  (fault_flag == (too_high_flag || too_low_flag)))
    else $error("cell flags inconsistent");

endmodule

bind cell_voltage_scan_monitor_unit cvsm_checker u_cvsm_checker (.*);

// ===== tb/sv/cvsm_scan_checker.sv =====
// ----------------------------------------------------------------------------
// cvsm_scan_checker
// Watches the cell, result and register ports of the scan monitor, predicts
// one report per closed scan and compares it field by field.
// ----------------------------------------------------------------------------
module cvsm_scan_checker
  import cvsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // cell channel
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CODE_W-1:0] cell_code,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              last_cell,
  // result channel
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SUM_W-1:0]  pack_voltage,
  input  logic              almost_full_flag,
  input  logic              full_flag,
  input  logic              low_warning_flag,
  input  logic              too_high_flag,
  input  logic              too_low_flag,
  input  logic              fault_flag,
  input  logic              pack_high_flag,
  input  logic              pack_low_flag,
  input  logic              any_not_read,
  input  logic [SOC_W-1:0]  state_of_charge,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  // to the testbench top
  output int unsigned       mismatch_count,
  output int unsigned       reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    flags_t           flags;
    logic             pack_high;
    logic             pack_low;
    logic             not_read;
    logic [SOC_W-1:0] soc;
  } scan_report_t;

  // Mirrored limits and the running scan state
  cfg_t             limits;
  logic [SUM_W-1:0] pack_sum;
  flags_t           scan_flags;
  logic             cell_missing;
  logic [SOC_W-1:0] held_soc;
  scan_report_t     reports_q[$];
  int unsigned      fail_count = 0;

  assign mismatch_count = fail_count;

  // Fold one cell into the scan; on the closing cell queue the pack report
  task automatic fold_cell(logic [CODE_W-1:0] code, logic [IDX_W-1:0] idx,
                           logic closes_scan);
    logic [SUM_W:0]    wide_sum;
    logic [SUM_W:0]    high_bound;
    logic              exempt;
    longint unsigned   ratio;
    scan_report_t      report;
    exempt = (idx == limits.skip_cell_index);
    if (code > NOT_READ_CODE) begin
      cell_missing = 1'b1;
    end else begin
      wide_sum = {1'b0, pack_sum} + {{(SUM_W+1-CODE_W){1'b0}}, code};
      pack_sum = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
      // absolute limits first, skipped on the exempt cell
      if (!exempt) begin
        if (code > limits.absolute_max_code) begin
          scan_flags.too_high = 1'b1;
          scan_flags.fault    = 1'b1;
        end else if (code < limits.absolute_min_code) begin
          scan_flags.too_low = 1'b1;
          scan_flags.fault   = 1'b1;
        end
      end
      if (code >= limits.over_voltage_code) begin
        scan_flags.full        = 1'b1;
        scan_flags.almost_full = 1'b1;
      end else if (code >= limits.almost_full_code) begin
        scan_flags.almost_full = 1'b1;
      end else if (code < limits.under_voltage_code && !exempt) begin
        scan_flags.low_warning = 1'b1;
      end
    end
    if (closes_scan) begin
      report          = '0;
      report.total    = pack_sum;
      report.flags    = scan_flags;
      report.not_read = cell_missing;
      high_bound      = {1'b0, pack_sum} + {1'b0, PACK_HIGH_MARGIN};
      // pack flags only with every cell read; otherwise refresh the SoC
      if (!cell_missing && high_bound > {1'b0, limits.pack_full_code}) begin
        report.pack_high = 1'b1;
      end else if (!cell_missing && pack_sum < limits.pack_low_code) begin
        report.pack_low = 1'b1;
      end else begin
        if (limits.pack_full_code == '0) begin
          ratio = 64'd100;
        end else begin
          ratio = (64'(pack_sum) * 64'd100) / 64'(limits.pack_full_code);
        end
        held_soc = (ratio > 64'd100) ? SOC_MAX : SOC_W'(ratio);
      end
      report.soc = held_soc;
      reports_q.push_back(report);
      pack_sum     = '0;
      scan_flags   = '0;
      cell_missing = 1'b0;
    end
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    scan_report_t want;
    if (rst) begin
      limits = '{RST_OVER_VOLTAGE, RST_ALMOST_FULL, RST_UNDER_VOLTAGE,
                 RST_ABSOLUTE_MAX, RST_ABSOLUTE_MIN, RST_PACK_FULL,
                 RST_PACK_LOW, RST_SKIP_CELL};
      pack_sum     = '0;
      scan_flags   = '0;
      cell_missing = 1'b0;
      held_soc     = '0;
      reports_q.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_OVER_VOLTAGE:  limits.over_voltage_code  = pwdata[CODE_W-1:0];
          REG_ALMOST_FULL:   limits.almost_full_code   = pwdata[CODE_W-1:0];
          REG_UNDER_VOLTAGE: limits.under_voltage_code = pwdata[CODE_W-1:0];
          REG_ABSOLUTE_MAX:  limits.absolute_max_code  = pwdata[CODE_W-1:0];
          REG_ABSOLUTE_MIN:  limits.absolute_min_code  = pwdata[CODE_W-1:0];
          REG_PACK_FULL:     limits.pack_full_code     = pwdata[SUM_W-1:0];
          REG_PACK_LOW:      limits.pack_low_code      = pwdata[SUM_W-1:0];
          REG_SKIP_CELL:     limits.skip_cell_index    = pwdata[IDX_W-1:0];
          default: ;
        endcase
      end
      // compare each delivered report with the oldest prediction
      if (out_valid && !out_stall) begin
        if (reports_q.size() == 0) begin
          $error("unexpected scan report, pack_voltage %0d", pack_voltage);
          fail_count++;
        end else begin
          want = reports_q.pop_front();
          compare_field("pack_voltage", 32'(want.total), 32'(pack_voltage));
          compare_field("almost_full_flag", 32'(want.flags.almost_full),
                        32'(almost_full_flag));
          compare_field("full_flag", 32'(want.flags.full), 32'(full_flag));
          compare_field("low_warning_flag", 32'(want.flags.low_warning),
                        32'(low_warning_flag));
          compare_field("too_high_flag", 32'(want.flags.too_high), 32'(too_high_flag));
          compare_field("too_low_flag", 32'(want.flags.too_low), 32'(too_low_flag));
          compare_field("fault_flag", 32'(want.flags.fault), 32'(fault_flag));
          compare_field("pack_high_flag", 32'(want.pack_high), 32'(pack_high_flag));
          compare_field("pack_low_flag", 32'(want.pack_low), 32'(pack_low_flag));
          compare_field("any_not_read", 32'(want.not_read), 32'(any_not_read));
          compare_field("state_of_charge", 32'(want.soc), 32'(state_of_charge));
        end
      end
      // predict from each accepted request
      if (in_valid && !in_stall) begin
        fold_cell(cell_code, cell_index, last_cell);
      end
    end
    reports_due <= reports_q.size();
  end

endmodule

// ===== tb/sv/cell_voltage_scan_monitor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_scan_monitor_unit_tb
// Drives pack scans through the scan monitor under several limit settings:
// a directed set of boundary cells, two scans long enough to saturate the
// sum, then random scans with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module cell_voltage_scan_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvsm_pkg::*;

  localparam int unsigned CELLS_PER_IC     = 12;
  localparam int unsigned NUM_MONITOR_IC   = 8;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned LONG_SCAN_CELLS  = 262;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned PHASE_CELLS      = 100;
  localparam int unsigned HOLD_AFTER_CELLS = 700;
  localparam int unsigned LONG_HOLD_CYCLES = 3000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CODE_W-1:0] cell_code = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              last_cell = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SUM_W-1:0]  pack_voltage;
  logic              almost_full_flag;
  logic              full_flag;
  logic              low_warning_flag;
  logic              too_high_flag;
  logic              too_low_flag;
  logic              fault_flag;
  logic              pack_high_flag;
  logic              pack_low_flag;
  logic              any_not_read;
  logic [SOC_W-1:0]  state_of_charge;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned mismatch_count;
  int unsigned reports_due;
  int unsigned cells_sent = 0;
  int unsigned burst_left = 0;

  // Limits currently programmed, used to aim cell codes at the boundaries
  int lim_ov   = int'(RST_OVER_VOLTAGE);
  int lim_af   = int'(RST_ALMOST_FULL);
  int lim_uv   = int'(RST_UNDER_VOLTAGE);
  int lim_amax = int'(RST_ABSOLUTE_MAX);
  int lim_amin = int'(RST_ABSOLUTE_MIN);

  cell_voltage_scan_monitor_unit i_dut (.*);

  cvsm_scan_checker i_checker (.*);

  always #5 clk = ~clk;

  // Write one register: setup cycle, then access cycle
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_limits(int ov, int af, int uv, int amax, int amin,
                                int pfull, int plow, int skip);
    lim_ov   = ov;
    lim_af   = af;
    lim_uv   = uv;
    lim_amax = amax;
    lim_amin = amin;
    write_reg(REG_OVER_VOLTAGE, ov);
    write_reg(REG_ALMOST_FULL, af);
    write_reg(REG_UNDER_VOLTAGE, uv);
    write_reg(REG_ABSOLUTE_MAX, amax);
    write_reg(REG_ABSOLUTE_MIN, amin);
    write_reg(REG_PACK_FULL, pfull);
    write_reg(REG_PACK_LOW, plow);
    write_reg(REG_SKIP_CELL, skip);
  endtask

  // Drop the request, wait for every report, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one cell; a new burst may open with a gap
  task automatic send_cell(logic [CODE_W-1:0] code, logic [IDX_W-1:0] idx,
                           logic closes_scan);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    cell_code  <= code;
    cell_index <= idx;
    last_cell  <= closes_scan;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  // Mostly realistic codes, with extremes and codes right at the limits
  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    int near;
    sel = $urandom_range(0, 31);
    case (sel)
      0: return '0;
      1: return '1;
      2: return ($urandom_range(0, 1) == 1) ? 16'd65001 : 16'd65000;
      3, 4, 5: begin
        case ($urandom_range(0, 4))
          0:       near = lim_ov;
          1:       near = lim_af;
          2:       near = lim_uv;
          3:       near = lim_amax;
          default: near = lim_amin;
        endcase
        near = near + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return CODE_W'(near);
      end
      6, 7: return CODE_W'($urandom_range(0, 65535));
      default: return CODE_W'($urandom_range(23000, 44000));
    endcase
  endfunction

  task automatic send_scan(int unsigned length);
    bit tidy;
    logic [IDX_W-1:0] idx;
    tidy = ($urandom_range(0, 3) != 0);
    for (int unsigned n = 0; n < length; n++) begin
      idx = tidy ? IDX_W'(n % CELLS_PER_IC) : IDX_W'($urandom_range(0, 15));
      send_cell(pick_code(), idx, n == length - 1);
    end
  endtask

  // Choose the limits of one random phase
  task automatic pick_limits(int unsigned phase);
    int ov, af, uv, amax, amin, pfull, plow;
    case (phase % 4)
      0, 2: begin
        ov    = $urandom_range(39000, 44000);
        af    = ov - int'($urandom_range(0, 3000));
        uv    = $urandom_range(24000, 30000);
        amax  = ov + int'($urandom_range(0, 1500));
        amin  = uv - int'($urandom_range(0, 2000));
        pfull = (phase % 4 == 0) ? $urandom_range(100000, 800000) : $urandom_range(1, 400000);
        plow  = $urandom_range(0, pfull);
        program_limits(ov, af, uv, amax, amin, pfull, plow, $urandom_range(0, 15));
      end
      1: begin
        program_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(1, 16777215),
                       $urandom_range(0, 16777215), $urandom_range(0, 15));
      end
      default: begin
        if ((phase / 4) % 2 == 0) begin
          program_limits(0, 0, 0, 0, 0, 1, 0, 0);
        end else begin
          program_limits(65535, 65535, 65535, 65535, 65535, 16777215, 16777215, 15);
        end
      end
    endcase
  endtask

  initial begin : cell_source
    int unsigned phase_start;
    int unsigned length;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default limits: every class of cell, closed by a cell not read
    send_cell(16'd42001, 4'd0, 1'b0);
    send_cell(16'd41600, 4'd1, 1'b0);
    send_cell(16'd40000, 4'd2, 1'b0);
    send_cell(16'd25999, 4'd3, 1'b0);
    send_cell(16'd24999, 4'd5, 1'b0);
    send_cell(16'd0, 4'd11, 1'b0);
    send_cell(16'd65000, 4'd13, 1'b0);
    send_cell(16'd65001, 4'd15, 1'b1);
    // pack low with the SoC held from the scan before
    send_cell(16'd30000, 4'd7, 1'b1);
    // nothing read at all
    send_cell(16'd65535, 4'd10, 1'b1);
    settle_block();

    // ordinary SoC with every cell read
    program_limits(41600, 40000, 26000, 42000, 25000, 200000, 10000, 5);
    send_cell(16'd60000, 4'd0, 1'b0);
    send_cell(16'd40500, 4'd1, 1'b1);
    settle_block();

    // lowest limits: SoC saturates, then a tiny full level forces pack high
    program_limits(0, 0, 0, 0, 0, 1, 0, 0);
    send_cell(16'd65000, 4'd8, 1'b0);
    send_cell(16'd65535, 4'd12, 1'b1);
    send_cell(16'd0, 4'd0, 1'b1);
    settle_block();

    // highest limits, exempt cell at the top index
    program_limits(65535, 65535, 65535, 65535, 65535, 16777215, 16777215, 15);
    send_cell(16'd65000, 4'd15, 1'b0);
    send_cell(16'd1, 4'd14, 1'b0);
    send_cell(16'd32768, 4'd9, 1'b1);
    settle_block();

    // two scans long enough to saturate the sum, the second missing a cell
    program_limits(int'(RST_OVER_VOLTAGE), int'(RST_ALMOST_FULL),
                   int'(RST_UNDER_VOLTAGE), int'(RST_ABSOLUTE_MAX),
                   int'(RST_ABSOLUTE_MIN), int'(RST_PACK_FULL),
                   int'(RST_PACK_LOW), int'(RST_SKIP_CELL));
    for (int k = 0; k < 2; k++) begin
      for (int n = 0; n < LONG_SCAN_CELLS; n++) begin
        send_cell((k == 1 && n == 100) ? 16'hFFFF : CODE_W'($urandom_range(64800, 65000)),
                  IDX_W'(n % CELLS_PER_IC), n == LONG_SCAN_CELLS - 1);
      end
    end
    settle_block();

    // random scans, new limits per phase
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      pick_limits(phase);
      phase_start = cells_sent;
      while (cells_sent - phase_start < PHASE_CELLS) begin
        length = ($urandom_range(0, 9) == 0) ? NUM_MONITOR_IC * CELLS_PER_IC
                                             : $urandom_range(1, 16);
        send_scan(length);
      end
      settle_block();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: stall patterns of its own, one long hold-off mid-run
  initial begin : result_sink
    int unsigned span;
    int unsigned mode;
    bit held_long;
    held_long = 1'b0;
    forever begin
      if (!held_long && cells_sent >= HOLD_AFTER_CELLS) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 200);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Hard stop
  initial begin : watchdog
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
